@@ rtl/huffman_tree_rle_decoder_macros.svh @@
// Assertion macros for the tree decoder with run-length escapes.
// Needs nothing else; included by the files that carry assertions.
`ifndef HUFFMAN_TREE_RLE_DECODER_MACROS_SVH
`define HUFFMAN_TREE_RLE_DECODER_MACROS_SVH

// This property must hold at every rising clock edge outside reset.
`define HTRD_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// This consequence must hold in the cycle after the antecedent.
`define HTRD_ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

@@ rtl/htrd_pkg.sv @@
// Shared constants and types for the tree decoder with run-length escapes.
// No dependencies.
package htrd_pkg;

    // Size of the tree store in bytes; it is held as two byte-wide banks.
    localparam int TREE_BYTES = 2048;
    localparam int TREE_WORDS = (TREE_BYTES + 1) / 2;
    localparam int WORD_AW    = (TREE_WORDS > 1) ? $clog2(TREE_WORDS) : 1;

    // Largest tree size that the store accepts, at the width of a header plus one.
    localparam logic [16:0] SIZE_LIMIT = 17'(TREE_BYTES);

    // Leaf values below this are literal bytes.
    localparam logic [14:0] LIT_LIMIT = 15'h100;

    // Low bytes of run codes that start a count escape.
    localparam logic [7:0] RUN_ESC_SINGLE = 8'h00;
    localparam logic [7:0] RUN_ESC_PAIR   = 8'h01;

    typedef enum logic [1:0] {
        ESC_NORMAL,
        ESC_SINGLE,
        ESC_PAIR_HI,
        ESC_PAIR_LO
    } t_esc;

endpackage

@@ rtl/huffman_tree_rle_decoder.sv @@
// Header and tree bytes are taken in the idle state (an oversized tree raises
// an error and passes through the flush state); for a data byte: an accept,
// then per bit a tree-store read and a leaf evaluation, then a flush. Results
// go from the pending slot to a registered output; no new data byte is taken
// until the last one is flushed, and a stalled output holds the bit walk.
// Reset (synchronous, active low) clears sequencer, frame and valid state only.
`include "huffman_tree_rle_decoder_macros.svh"

module huffman_tree_rle_decoder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // [7:0] in_byte
    input  logic        i_s_axis_tlast,
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [23:0] o_m_axis_tdata,   // [7:0] out_byte, [23:8] run_length
    output logic        o_m_axis_tuser,   // [0] error
    output logic        o_m_axis_tlast
);

    typedef enum logic [2:0] {
        PH_SIZE_LO,
        PH_SIZE_HI,
        PH_LOAD,
        PH_DATA,
        PH_IGNORE
    } t_phase;

    typedef enum logic [1:0] {
        SQ_IDLE,
        SQ_ADV,
        SQ_BIT,
        SQ_FLUSH
    } t_seq;

    t_seq               r_seq, n_seq;
    t_phase             r_phase, n_phase;
    logic [15:0]        r_size, n_size;
    logic [15:0]        r_load, n_load;
    logic [14:0]        r_node, n_node;
    htrd_pkg::t_esc     r_esc, n_esc;
    logic [7:0]         r_last_byte, n_last_byte;
    logic [7:0]         r_count_hi, n_count_hi;
    logic [7:0]         r_byte, n_byte;
    logic [2:0]         r_bit, n_bit;
    logic               r_last, n_last;

    logic               r_pend_v, n_pend_v;
    logic [7:0]         r_pend_byte, n_pend_byte;
    logic [15:0]        r_pend_len, n_pend_len;
    logic               r_pend_err, n_pend_err;

    logic               r_o_valid, n_o_valid;
    logic [7:0]         r_o_byte, n_o_byte;
    logic [15:0]        r_o_len, n_o_len;
    logic               r_o_err, n_o_err;
    logic               r_o_last, n_o_last;

    logic [7:0]         r_rd_lo, r_rd_hi;
    logic [7:0]         mem_lo [htrd_pkg::TREE_WORDS];
    logic [7:0]         mem_hi [htrd_pkg::TREE_WORDS];

    logic               in_acc;
    logic               slot_free;
    logic               can_emit;
    logic               push;
    logic               push_last;
    logic               wr_en;
    logic               rd_en;
    logic [htrd_pkg::WORD_AW-1:0] wr_idx;
    logic [htrd_pkg::WORD_AW-1:0] rd_idx;
    logic [15:0]        size_hdr;

    logic               adv_bit;
    logic [14:0]        adv_node;
    logic               adv_oob;

    logic [15:0]        word;
    logic [14:0]        val;
    logic [7:0]         low;
    logic               gen_v;
    logic [7:0]         gen_byte;
    logic [15:0]        gen_len;
    htrd_pkg::t_esc     bit_esc;
    logic [7:0]         bit_last_byte;
    logic [7:0]         bit_count_hi;
    logic [14:0]        bit_node;

    assign o_s_axis_tready = (r_seq == SQ_IDLE);
    assign in_acc          = i_s_axis_tvalid && o_s_axis_tready;
    assign slot_free       = !r_o_valid || i_m_axis_tready;
    assign can_emit        = !r_pend_v || slot_free;
    assign size_hdr        = {i_s_axis_tdata, r_size[7:0]};

    assign adv_bit  = r_byte[r_bit];
    assign adv_node = r_node + {14'd0, adv_bit};
    // The word's upper byte must lie inside the loaded tree.
    assign adv_oob  = ({adv_node, 1'b1} >= r_size);

    assign wr_idx = r_load[htrd_pkg::WORD_AW:1];
    assign rd_idx = adv_node[htrd_pkg::WORD_AW-1:0];

    assign word = {r_rd_hi, r_rd_lo};
    assign val  = word[14:0];
    assign low  = word[7:0];

    // Evaluation of the tree word fetched for the current bit.
    always_comb begin
        gen_v         = 1'b0;
        gen_byte      = r_last_byte;
        gen_len       = 16'd0;
        bit_esc       = r_esc;
        bit_last_byte = r_last_byte;
        bit_count_hi  = r_count_hi;
        bit_node      = 15'd0;
        if (!word[15]) begin
            bit_node = word[15:1];
        end else begin
            case (r_esc)
                htrd_pkg::ESC_NORMAL: begin
                    if (val < htrd_pkg::LIT_LIMIT) begin
                        bit_last_byte = low;
                        gen_v         = 1'b1;
                        gen_byte      = low;
                        gen_len       = 16'd1;
                    end else if (low == htrd_pkg::RUN_ESC_SINGLE) begin
                        bit_esc = htrd_pkg::ESC_SINGLE;
                    end else if (low == htrd_pkg::RUN_ESC_PAIR) begin
                        bit_esc = htrd_pkg::ESC_PAIR_HI;
                    end else begin
                        gen_v   = 1'b1;
                        gen_len = {8'h00, low};
                    end
                end
                htrd_pkg::ESC_SINGLE: begin
                    gen_v   = (val != 15'd0);
                    gen_len = {1'b0, val};
                    bit_esc = htrd_pkg::ESC_NORMAL;
                end
                htrd_pkg::ESC_PAIR_HI: begin
                    bit_count_hi = low;
                    bit_esc      = htrd_pkg::ESC_PAIR_LO;
                end
                default: begin
                    gen_v   = ({r_count_hi, low} != 16'd0);
                    gen_len = {r_count_hi, low};
                    bit_esc = htrd_pkg::ESC_NORMAL;
                end
            endcase
        end
    end

    // Sequencer. A new result waits in the pending slot until the next one
    // arrives or the byte ends, so that the final one can be marked.
    always_comb begin
        n_seq       = r_seq;
        n_phase     = r_phase;
        n_size      = r_size;
        n_load      = r_load;
        n_node      = r_node;
        n_esc       = r_esc;
        n_last_byte = r_last_byte;
        n_count_hi  = r_count_hi;
        n_byte      = r_byte;
        n_bit       = r_bit;
        n_last      = r_last;
        n_pend_v    = r_pend_v;
        n_pend_byte = r_pend_byte;
        n_pend_len  = r_pend_len;
        n_pend_err  = r_pend_err;
        push        = 1'b0;
        push_last   = 1'b0;
        wr_en       = 1'b0;
        rd_en       = 1'b0;

        case (r_seq)
            SQ_IDLE: begin
                if (in_acc) begin
                    n_byte = i_s_axis_tdata;
                    n_last = i_s_axis_tlast;
                    case (r_phase)
                        PH_SIZE_LO: begin
                            n_size  = {8'h00, i_s_axis_tdata};
                            n_phase = PH_SIZE_HI;
                        end
                        PH_SIZE_HI: begin
                            n_size = size_hdr;
                            n_load = 16'd0;
                            if ({1'b0, size_hdr} > htrd_pkg::SIZE_LIMIT) begin
                                n_pend_v    = 1'b1;
                                n_pend_byte = 8'h00;
                                n_pend_len  = 16'd0;
                                n_pend_err  = 1'b1;
                                n_phase     = PH_IGNORE;
                                n_seq       = SQ_FLUSH;
                            end else if (size_hdr == 16'd0) begin
                                n_phase = PH_DATA;
                            end else begin
                                n_phase = PH_LOAD;
                            end
                        end
                        PH_LOAD: begin
                            if (r_load < r_size) begin
                                wr_en  = 1'b1;
                                n_load = r_load + 16'd1;
                            end
                            if (n_load >= r_size) begin
                                n_phase = PH_DATA;
                            end
                        end
                        PH_DATA: begin
                            n_bit = 3'd7;
                            n_seq = SQ_ADV;
                        end
                        default: begin
                        end
                    endcase
                    if (i_s_axis_tlast && (n_seq == SQ_IDLE)) begin
                        n_phase     = PH_SIZE_LO;
                        n_size      = 16'd0;
                        n_load      = 16'd0;
                        n_node      = 15'd0;
                        n_esc       = htrd_pkg::ESC_NORMAL;
                        n_last_byte = 8'h00;
                        n_count_hi  = 8'h00;
                    end
                end
            end
            SQ_ADV: begin
                if (adv_oob) begin
                    if (can_emit) begin
                        push        = r_pend_v;
                        n_pend_v    = 1'b1;
                        n_pend_byte = 8'h00;
                        n_pend_len  = 16'd0;
                        n_pend_err  = 1'b1;
                        n_phase     = PH_IGNORE;
                        n_seq       = SQ_FLUSH;
                    end
                end else begin
                    rd_en  = 1'b1;
                    n_node = adv_node;
                    n_seq  = SQ_BIT;
                end
            end
            SQ_BIT: begin
                if (!gen_v || can_emit) begin
                    push = gen_v && r_pend_v;
                    if (gen_v) begin
                        n_pend_v    = 1'b1;
                        n_pend_byte = gen_byte;
                        n_pend_len  = gen_len;
                        n_pend_err  = 1'b0;
                    end
                    n_node      = bit_node;
                    n_esc       = bit_esc;
                    n_last_byte = bit_last_byte;
                    n_count_hi  = bit_count_hi;
                    if (r_bit == 3'd0) begin
                        n_seq = SQ_FLUSH;
                    end else begin
                        n_bit = r_bit - 3'd1;
                        n_seq = SQ_ADV;
                    end
                end
            end
            default: begin
                if (!r_pend_v || slot_free) begin
                    push      = r_pend_v;
                    push_last = 1'b1;
                    n_pend_v  = 1'b0;
                    n_seq     = SQ_IDLE;
                    if (r_last) begin
                        n_phase     = PH_SIZE_LO;
                        n_size      = 16'd0;
                        n_load      = 16'd0;
                        n_node      = 15'd0;
                        n_esc       = htrd_pkg::ESC_NORMAL;
                        n_last_byte = 8'h00;
                        n_count_hi  = 8'h00;
                    end
                end
            end
        endcase

        if (push) begin
            n_o_valid = 1'b1;
            n_o_byte  = r_pend_byte;
            n_o_len   = r_pend_len;
            n_o_err   = r_pend_err;
            n_o_last  = push_last;
        end else begin
            n_o_valid = r_o_valid && !i_m_axis_tready;
            n_o_byte  = r_o_byte;
            n_o_len   = r_o_len;
            n_o_err   = r_o_err;
            n_o_last  = r_o_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seq       <= SQ_IDLE;
            r_phase     <= PH_SIZE_LO;
            r_size      <= 16'd0;
            r_load      <= 16'd0;
            r_node      <= 15'd0;
            r_esc       <= htrd_pkg::ESC_NORMAL;
            r_last_byte <= 8'h00;
            r_count_hi  <= 8'h00;
            r_pend_v    <= 1'b0;
            r_o_valid   <= 1'b0;
        end else begin
            r_seq       <= n_seq;
            r_phase     <= n_phase;
            r_size      <= n_size;
            r_load      <= n_load;
            r_node      <= n_node;
            r_esc       <= n_esc;
            r_last_byte <= n_last_byte;
            r_count_hi  <= n_count_hi;
            r_pend_v    <= n_pend_v;
            r_o_valid   <= n_o_valid;
        end
        r_byte      <= n_byte;
        r_bit       <= n_bit;
        r_last      <= n_last;
        r_pend_byte <= n_pend_byte;
        r_pend_len  <= n_pend_len;
        r_pend_err  <= n_pend_err;
        r_o_byte    <= n_o_byte;
        r_o_len     <= n_o_len;
        r_o_err     <= n_o_err;
        r_o_last    <= n_o_last;
    end

    // Even tree bytes go to the low bank, odd ones to the high bank.
    always_ff @(posedge i_clk) begin
        if (wr_en && !r_load[0]) begin
            mem_lo[wr_idx] <= i_s_axis_tdata;
        end
        if (rd_en) begin
            r_rd_lo <= mem_lo[rd_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en && r_load[0]) begin
            mem_hi[wr_idx] <= i_s_axis_tdata;
        end
        if (rd_en) begin
            r_rd_hi <= mem_hi[rd_idx];
        end
    end

    assign o_m_axis_tvalid = r_o_valid;
    assign o_m_axis_tdata  = {r_o_len, r_o_byte};
    assign o_m_axis_tuser  = r_o_err;
    assign o_m_axis_tlast  = r_o_last;

    `HTRD_ASSERT(a_idle_no_pend, i_clk, i_rst_n, (r_seq == SQ_IDLE) |-> !r_pend_v, "pending result left behind in idle")
    `HTRD_ASSERT(a_walk_in_tree, i_clk, i_rst_n, (r_seq == SQ_BIT) |-> ({r_node, 1'b1} < r_size), "tree word read outside the loaded tree")
    `HTRD_ASSERT(a_err_is_last, i_clk, i_rst_n, (r_o_valid && r_o_err) |-> r_o_last, "error result not marked as final")
    `HTRD_ASSERT(a_len_vs_err, i_clk, i_rst_n, r_o_valid |-> ((r_o_len == 16'd0) == r_o_err), "zero run length on a non-error result")
    `HTRD_ASSERT_NEXT(a_flush_marks_last, i_clk, i_rst_n, (r_seq == SQ_FLUSH) && r_pend_v && slot_free, r_o_valid && r_o_last && (r_seq == SQ_IDLE), "flushed result not delivered as final")

endmodule
